### rtl/cbs_pkg.sv
`default_nettype none

package cbs_pkg;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_LOAD  = 2'd1,
      ST_RUN   = 2'd2,
      ST_SHIFT = 2'd3
   } ctrl_state_type;

   // which four points make up the segment being sampled
   typedef enum logic [1:0] {
      SEG_START = 2'd0,
      SEG_MID   = 2'd1,
      SEG_END   = 2'd2
   } seg_kind_type;

   // controller to datapath
   typedef struct packed {
      logic         capture;   // latch the incoming point
      logic         load_seg;  // copy segment points, restart u
      seg_kind_type seg_kind;
      logic         issue;     // launch one sample into the pipeline
      logic         end_flag;  // sample belongs to the end segment
      logic         last_flag; // sample is the last of the item's run
      logic         shift;     // push incoming point into history
   } cbs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic adv;      // pipeline moves this cycle
      logic seg_free; // no sample still waiting for the segment points
      logic seg_last; // the sample at u now is the last of its segment
   } cbs_status_type;

endpackage

`default_nettype wire

### rtl/cbs_ctrl.sv
`default_nettype none

module cbs_ctrl
   import cbs_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_last_point,
   output logic                req_stall,
   input  wire cbs_status_type status,
   output cbs_cmd_type         cmd
);

   ctrl_state_type state_ff, state_in;
   seg_kind_type   kind_ff, kind_in;
   logic [1:0]     seen_ff, seen_in;
   logic           last_ff, last_in;
   logic           has_end_ff, has_end_in;
   logic           more_seg;

   // an end segment still follows the one being sampled
   assign more_seg = has_end_ff && (kind_ff != SEG_END);

   always_comb begin : next_state
      state_in   = state_ff;
      kind_in    = kind_ff;
      seen_in    = seen_ff;
      last_in    = last_ff;
      has_end_in = has_end_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               last_in    = req_last_point;
               has_end_in = req_last_point && (seen_ff >= 2'd2);
               kind_in    = (seen_ff == 2'd2) ? SEG_START : SEG_MID;
               state_in   = (seen_ff >= 2'd2) ? ST_LOAD : ST_SHIFT;
            end
         end
         ST_LOAD: begin
            if (status.seg_free) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.adv && status.seg_last) begin
               if (more_seg) begin
                  kind_in  = SEG_END;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            state_in = ST_IDLE;
            if (last_ff) begin
               seen_in = 2'd0;
            end else if (seen_ff != 2'd3) begin
               seen_in = seen_ff + 2'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin : outputs
      req_stall     = (state_ff != ST_IDLE);
      cmd.capture   = (state_ff == ST_IDLE) && req_valid;
      cmd.load_seg  = (state_ff == ST_LOAD) && status.seg_free;
      cmd.seg_kind  = kind_ff;
      cmd.issue     = (state_ff == ST_RUN) && status.adv;
      cmd.end_flag  = (kind_ff == SEG_END);
      cmd.last_flag = status.seg_last && !more_seg;
      cmd.shift     = (state_ff == ST_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         kind_ff    <= SEG_MID;
         seen_ff    <= 2'd0;
         last_ff    <= 1'b0;
         has_end_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         kind_ff    <= kind_in;
         seen_ff    <= seen_in;
         last_ff    <= last_in;
         has_end_ff <= has_end_in;
      end
   end

endmodule

`default_nettype wire

### rtl/cbs_datapath.sv
`default_nettype none

module cbs_datapath
   import cbs_pkg::*;
#(
   parameter int COORD_BITS      = 24,
   parameter int U_FRAC_BITS     = 16,
   parameter int MAX_SEG_SAMPLES = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic        [U_FRAC_BITS:0]  csr_u_step,
   input  wire logic signed [COORD_BITS-1:0] req_point_x,
   input  wire logic signed [COORD_BITS-1:0] req_point_y,
   input  wire logic signed [COORD_BITS-1:0] req_point_z,
   input  wire cbs_cmd_type                  cmd,
   output cbs_status_type                    status,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0]      rsp_curve_x,
   output logic signed [COORD_BITS-1:0]      rsp_curve_y,
   output logic signed [COORD_BITS-1:0]      rsp_curve_z,
   output logic                              rsp_end_segment,
   output logic                              rsp_last_of_run
);

   localparam int C   = COORD_BITS;
   localparam int F   = U_FRAC_BITS;
   localparam int UW  = F + 1;          // u, u^2, u^3 in [0, 1]
   localparam int UNW = F + 2;          // u plus one step
   localparam int KW  = $clog2(MAX_SEG_SAMPLES);
   localparam int PB  = C + 2;          // segment points incl. phantoms
   localparam int WB  = F + 4;          // signed weights up to 4.0
   localparam int NB  = WB + PB + 2;    // weighted sum
   localparam int TW  = NB - F;         // sum after the 2^(F+1) shift
   localparam int TB  = C + 1;          // clamped quotient by 2^(F+1)

   localparam logic [UW-1:0]        U_STEP_RESET =
      UW'((64'd1 << F) / MAX_SEG_SAMPLES + 64'd1);
   localparam logic [UNW-1:0]       U_ONE    = UNW'(1) << F;
   localparam logic [2*UW-1:0]      U_HALF2  = (2*UW)'(1) << (F - 1);
   localparam logic [KW-1:0]        K_LAST   = KW'(MAX_SEG_SAMPLES - 1);
   localparam logic signed [WB-1:0] W_ONE    = WB'(1) << F;
   localparam logic [NB:0]          T_RND    = (NB + 1)'(3) << F;
   localparam logic [TB-1:0]        T_LIMIT  = (TB'(3) << (C - 1)) + TB'(2);
   localparam logic [TB-2:0]        RECIP    = (TB - 1)'((64'd1 << TB) / 64'd3);
   localparam logic [C-1:0]         Q_HALF   = C'(1) << (C - 1);
   localparam logic [C-1:0]         COORD_MAX = Q_HALF - C'(1);

   // configuration and sample sequencing
   logic [UW-1:0]  u_step_ff;
   logic [UW-1:0]  u_ff;
   logic [KW-1:0]  k_ff;
   logic [UNW-1:0] u_next;

   // point history, incoming point and segment points
   logic signed [C-1:0]  pin_ff [3];
   logic signed [C-1:0]  rp_ff  [3][3];
   logic signed [PB-1:0] seg_ff [4][3];
   logic signed [PB-1:0] seg_in [4][3];

   // pipeline
   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, rsp_valid_ff;
   logic e1_ff, e2_ff, e3_ff, e4_ff, e5_ff, e6_ff, e7_ff;
   logic l1_ff, l2_ff, l3_ff, l4_ff, l5_ff, l6_ff, l7_ff;

   logic [2*UW-1:0] usq1_ff;
   logic [UW-1:0]   u1_ff;
   logic [2*UW-1:0] usum2;
   logic [UW-1:0]   u2c;
   logic [2*UW-1:0] p3_2_ff;
   logic [UW-1:0]   u_2_ff, u2_2_ff;
   logic [2*UW-1:0] psum3;
   logic [UW-1:0]   u3c;
   logic signed [WB-1:0] s1, s2, s3;
   logic signed [WB-1:0] w_in [4];
   logic signed [WB-1:0] w3_ff [4];
   logic signed [WB+PB-1:0] prod4_ff [4][3];
   logic signed [NB-1:0] num5_ff [3];

   logic [NB-1:0] mag6  [3];
   logic [NB:0]   addh6 [3];
   logic [TW-1:0] t6    [3];
   logic [TB-1:0] tc6_in [3];
   logic [TB-1:0] tc6_ff [3];
   logic          neg6_ff [3];

   logic [2*TB-2:0] prq7 [3];
   logic [C-1:0]    qe7_ff [3];
   logic [TB-1:0]   tc7_ff [3];
   logic            neg7_ff [3];

   logic [TB-1:0] rem8 [3];
   logic [C-1:0]  qf8  [3];
   logic [C-1:0]  res8 [3];
   logic signed [C-1:0] rsp_c_ff [3];
   logic rsp_end_ff, rsp_last_ff;

   assign adv    = !(rsp_valid_ff && rsp_stall);
   assign u_next = {1'b0, u_ff} + {1'b0, u_step_ff};

   assign status.adv      = adv;
   assign status.seg_free = !(v1_ff || v2_ff || v3_ff);
   assign status.seg_last = (u_next > U_ONE) || (k_ff == K_LAST);

   // ---------------- configuration, u accumulator ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         u_step_ff <= U_STEP_RESET;
         u_ff      <= '0;
         k_ff      <= '0;
      end else begin
         if (csr_we) begin
            u_step_ff <= csr_u_step;
         end
         if (cmd.load_seg) begin
            u_ff <= '0;
            k_ff <= '0;
         end else if (cmd.issue) begin
            u_ff <= u_next[UW-1:0];
            k_ff <= k_ff + KW'(1);
         end
      end
   end

   // ---------------- points ----------------
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         unique case (cmd.seg_kind)
            SEG_START: begin
               seg_in[0][j] = (PB'(rp_ff[1][j]) <<< 1) - PB'(rp_ff[2][j]);
               seg_in[1][j] = PB'(rp_ff[1][j]);
               seg_in[2][j] = PB'(rp_ff[2][j]);
               seg_in[3][j] = PB'(pin_ff[j]);
            end
            SEG_END: begin
               seg_in[0][j] = PB'(rp_ff[1][j]);
               seg_in[1][j] = PB'(rp_ff[2][j]);
               seg_in[2][j] = PB'(pin_ff[j]);
               seg_in[3][j] = (PB'(pin_ff[j]) <<< 1) - PB'(rp_ff[2][j]);
            end
            SEG_MID: begin
               seg_in[0][j] = PB'(rp_ff[0][j]);
               seg_in[1][j] = PB'(rp_ff[1][j]);
               seg_in[2][j] = PB'(rp_ff[2][j]);
               seg_in[3][j] = PB'(pin_ff[j]);
            end
            default: begin
               seg_in[0][j] = PB'(rp_ff[0][j]);
               seg_in[1][j] = PB'(rp_ff[1][j]);
               seg_in[2][j] = PB'(rp_ff[2][j]);
               seg_in[3][j] = PB'(pin_ff[j]);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pin_ff[0] <= req_point_x;
         pin_ff[1] <= req_point_y;
         pin_ff[2] <= req_point_z;
      end
      if (cmd.shift) begin
         rp_ff[0] <= rp_ff[1];
         rp_ff[1] <= rp_ff[2];
         rp_ff[2] <= pin_ff;
      end
      if (cmd.load_seg) begin
         seg_ff <= seg_in;
      end
   end

   // ---------------- sample pipeline ----------------
   always_comb begin
      usum2 = usq1_ff + U_HALF2;
      u2c   = usum2[F +: UW];
      psum3 = p3_2_ff + U_HALF2;
      u3c   = psum3[F +: UW];
      s1    = signed'(WB'(u_2_ff));
      s2    = signed'(WB'(u2_2_ff));
      s3    = signed'(WB'(u3c));
      // basis weights scaled by 6 * 2^F
      w_in[0] = W_ONE - s3 + (s2 + (s2 <<< 1)) - (s1 + (s1 <<< 1));
      w_in[1] = (s3 + (s3 <<< 1)) - ((s2 <<< 2) + (s2 <<< 1)) + (W_ONE <<< 2);
      w_in[2] = W_ONE - (s3 + (s3 <<< 1)) + (s2 + (s2 <<< 1)) + (s1 + (s1 <<< 1));
      w_in[3] = s3;

      for (int j = 0; j < 3; j++) begin
         // divide by 6 * 2^F: round half away, shift out 2^(F+1), clamp, then / 3
         mag6[j]   = num5_ff[j][NB-1] ? -num5_ff[j] : num5_ff[j];
         addh6[j]  = {1'b0, mag6[j]} + T_RND;
         t6[j]     = addh6[j][NB:F+1];
         tc6_in[j] = (t6[j] > TW'(T_LIMIT)) ? T_LIMIT : t6[j][TB-1:0];

         prq7[j]   = tc6_ff[j] * RECIP;

         rem8[j]   = tc7_ff[j] - {qe7_ff[j], 1'b0} - TB'(qe7_ff[j]);
         qf8[j]    = (rem8[j] >= TB'(3)) ? qe7_ff[j] + C'(1) : qe7_ff[j];
         if (neg7_ff[j]) begin
            res8[j] = -qf8[j];
         end else if (qf8[j] == Q_HALF) begin
            res8[j] = COORD_MAX;
         end else begin
            res8[j] = qf8[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= cmd.issue;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         rsp_valid_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         usq1_ff <= u_ff * u_ff;
         u1_ff   <= u_ff;
         e1_ff   <= cmd.end_flag;
         l1_ff   <= cmd.last_flag;

         p3_2_ff <= u2c * u1_ff;
         u_2_ff  <= u1_ff;
         u2_2_ff <= u2c;
         e2_ff   <= e1_ff;
         l2_ff   <= l1_ff;

         w3_ff   <= w_in;
         e3_ff   <= e2_ff;
         l3_ff   <= l2_ff;

         for (int a = 0; a < 4; a++) begin
            for (int j = 0; j < 3; j++) begin
               prod4_ff[a][j] <= w3_ff[a] * seg_ff[a][j];
            end
         end
         e4_ff <= e3_ff;
         l4_ff <= l3_ff;

         for (int j = 0; j < 3; j++) begin
            num5_ff[j] <= NB'(prod4_ff[0][j]) + NB'(prod4_ff[1][j])
                        + NB'(prod4_ff[2][j]) + NB'(prod4_ff[3][j]);
         end
         e5_ff <= e4_ff;
         l5_ff <= l4_ff;

         for (int j = 0; j < 3; j++) begin
            tc6_ff[j]  <= tc6_in[j];
            neg6_ff[j] <= num5_ff[j][NB-1];
            qe7_ff[j]  <= prq7[j][TB +: C];
            tc7_ff[j]  <= tc6_ff[j];
            neg7_ff[j] <= neg6_ff[j];
            rsp_c_ff[j] <= signed'(res8[j]);
         end
         e6_ff       <= e5_ff;
         l6_ff       <= l5_ff;
         e7_ff       <= e6_ff;
         l7_ff       <= l6_ff;
         rsp_end_ff  <= e7_ff;
         rsp_last_ff <= l7_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_curve_x     = rsp_c_ff[0];
   assign rsp_curve_y     = rsp_c_ff[1];
   assign rsp_curve_z     = rsp_c_ff[2];
   assign rsp_end_segment = rsp_end_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

`default_nettype wire

### rtl/cubic_bspline_curve_sampler.sv
// channel  ports                          direction  handshake
// req      point_x/y/z, last_point       in         req_valid / req_stall
// rsp      curve_x/y/z, end_segment,      out        rsp_valid / rsp_stall
//          last_of_run
// csr      u_step                         in         csr_valid / csr_ready
//
// sequence: an item is accepted in idle, then each segment is loaded and its n samples
//   launched, n = min(floor(1/u_step) + 1, MAX_SEG_SAMPLES), then the history is updated
// up to two segments per item; a segment load waits for the front of the sample
//   pipeline to clear; samples are launched only while the pipeline moves
// reset: synchronous, active high; clears control state, u_step returns to 2^F/32 + 1
// stalls: rsp_stall freezes the whole sample pipeline while rsp_valid is high; req_stall is high while busy
`default_nettype none

module cubic_bspline_curve_sampler
   import cbs_pkg::*;
#(
   parameter int COORD_BITS      = 24,
   parameter int U_FRAC_BITS     = 16,
   parameter int MAX_SEG_SAMPLES = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // point input
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [COORD_BITS-1:0] req_point_x,
   input  wire logic signed [COORD_BITS-1:0] req_point_y,
   input  wire logic signed [COORD_BITS-1:0] req_point_z,
   input  wire logic                         req_last_point,
   // curve samples
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0]      rsp_curve_x,
   output logic signed [COORD_BITS-1:0]      rsp_curve_y,
   output logic signed [COORD_BITS-1:0]      rsp_curve_z,
   output logic                              rsp_end_segment,
   output logic                              rsp_last_of_run,
   // step register
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic        [U_FRAC_BITS:0]  csr_u_step
);

   cbs_cmd_type    cmd;
   cbs_status_type status;
   logic           csr_we;

   // the step register takes a write in any cycle
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   // controller: accepts a point, decides which segments it completes
   // (start, middle, end), loads each segment and launches its samples
   cbs_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_point (req_last_point),
      .req_stall      (req_stall),
      .status         (status),
      .cmd            (cmd)
   );

   // datapath: point history, segment points with phantom ends, u accumulator,
   // u^2 / u^3 / weight / product / sum / divide-by-6 pipeline, output register
   cbs_datapath #(
      .COORD_BITS      (COORD_BITS),
      .U_FRAC_BITS     (U_FRAC_BITS),
      .MAX_SEG_SAMPLES (MAX_SEG_SAMPLES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_u_step      (csr_u_step),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_curve_x     (rsp_curve_x),
      .rsp_curve_y     (rsp_curve_y),
      .rsp_curve_z     (rsp_curve_z),
      .rsp_end_segment (rsp_end_segment),
      .rsp_last_of_run (rsp_last_of_run)
   );

`ifndef NO_ASSERTIONS
   // segment points never change under a sample that still needs them
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_seg |-> status.seg_free)
      else $error("segment loaded while samples still in flight");

   // a sample is only launched when the pipeline moves
   a_issue_on_adv: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> status.adv)
      else $error("sample launched into a stalled pipeline");

   // an accepted item keeps the input closed in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input open right after accepting an item");
`endif

endmodule

`default_nettype wire

### tb/cubic_bspline_curve_sampler_tb.sv
`timescale 1ns / 100ps

module cubic_bspline_curve_sampler_tb;

   localparam int COORD_BITS      = 24;
   localparam int U_FRAC_BITS     = 16;
   localparam int MAX_SEG_SAMPLES = 32;

   localparam int RESET_CYCLES   = 11;
   localparam int SETTLE_CYCLES  = 24;   // history update plus 8 stage sample pipeline
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int REPORT_LIMIT   = 10;

   localparam longint U_ONE     = longint'(1) << U_FRAC_BITS;
   localparam longint U_HALF    = U_ONE / 2;
   localparam longint BLEND_DEN = 6 * U_ONE;
   localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;

   localparam logic [U_FRAC_BITS:0] STEP_MIN = 17'd2049;
   localparam logic [U_FRAC_BITS:0] STEP_MAX = 17'd65536;

   localparam logic signed [COORD_BITS-1:0] CMAX = 24'sh7fffff;
   localparam logic signed [COORD_BITS-1:0] CMIN = 24'sh800000;

   // control point held by the predictor, wide enough for exact phantom points
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } cpoint_type;

   // one expected curve sample
   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] z;
      logic                  end_seg;
      logic                  last_run;
   } curve_sample_type;

   logic clock;
   logic reset = 1'b1;

   logic                         req_valid      = 1'b0;
   logic                         req_stall;
   logic signed [COORD_BITS-1:0] req_point_x    = '0;
   logic signed [COORD_BITS-1:0] req_point_y    = '0;
   logic signed [COORD_BITS-1:0] req_point_z    = '0;
   logic                         req_last_point = 1'b0;

   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [COORD_BITS-1:0] rsp_curve_x;
   logic signed [COORD_BITS-1:0] rsp_curve_y;
   logic signed [COORD_BITS-1:0] rsp_curve_z;
   logic                         rsp_end_segment;
   logic                         rsp_last_of_run;

   logic                         csr_valid  = 1'b0;
   logic                         csr_ready;
   logic [U_FRAC_BITS:0]         csr_u_step = '0;

   // predictor state: three newest points, list position, step register
   cpoint_type           hull [3];
   int                   points_held;
   logic [U_FRAC_BITS:0] model_step;

   curve_sample_type sample_q [$];

   // idling controls shared between the test tasks and the stall process
   bit sender_idle        = 1'b1;
   bit rsp_idle_on        = 1'b1;
   int rsp_holdoff_cycles = 0;

   // run statistics
   int mismatches      = 0;
   int samples_checked = 0;
   int points_sent     = 0;
   int lists_sent      = 0;
   int settings_used   = 0;
   int blocked_cycles  = 0;

   cubic_bspline_curve_sampler #(
      .COORD_BITS      (COORD_BITS),
      .U_FRAC_BITS     (U_FRAC_BITS),
      .MAX_SEG_SAMPLES (MAX_SEG_SAMPLES)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .req_last_point  (req_last_point),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_curve_x     (rsp_curve_x),
      .rsp_curve_y     (rsp_curve_y),
      .rsp_curve_z     (rsp_curve_z),
      .rsp_end_segment (rsp_end_segment),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_u_step      (csr_u_step)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // phantom point reflected through the edge point
   function automatic cpoint_type mirror(cpoint_type edge_pt, cpoint_type inner);
      cpoint_type r;
      r.x = 2 * edge_pt.x - inner.x;
      r.y = 2 * edge_pt.y - inner.y;
      r.z = 2 * edge_pt.z - inner.z;
      return r;
   endfunction

   // weighted sum over 6 * 2^F, rounded half away from zero, then saturated
   function automatic logic [COORD_BITS-1:0] blend_axis(longint w0, longint w1, longint w2,
                                                         longint w3, longint a, longint b,
                                                         longint c, longint d);
      longint num;
      longint mag;
      longint q;
      longint r;
      num = w0 * a + w1 * b + w2 * c + w3 * d;
      mag = (num < 0) ? -num : num;
      q   = (mag + BLEND_DEN / 2) / BLEND_DEN;
      r   = (num < 0) ? -q : q;
      if (r > COORD_MAX) r = COORD_MAX;
      if (r < COORD_MIN) r = COORD_MIN;
      return r[COORD_BITS-1:0];
   endfunction

   // samples of one segment at u = k * step while u <= 1, capped in count
   task automatic push_segment(input cpoint_type a, input cpoint_type b, input cpoint_type c,
                               input cpoint_type d, input logic end_seg);
      longint           u, u2, u3;
      longint           w0, w1, w2, w3;
      longint           steps;
      int               n;
      curve_sample_type s;
      if (model_step == 0) begin
         n = MAX_SEG_SAMPLES;
      end else begin
         steps = U_ONE / longint'(model_step) + 1;
         n = (steps > MAX_SEG_SAMPLES) ? MAX_SEG_SAMPLES : int'(steps);
      end
      for (int k = 0; k < n; k++) begin
         u  = longint'(k) * longint'(model_step);
         u2 = (u * u + U_HALF) >>> U_FRAC_BITS;
         u3 = (u2 * u + U_HALF) >>> U_FRAC_BITS;
         // basis weights times 6 * 2^F, they sum to 6 * 2^F exactly
         w0 = -u3 + 3 * u2 - 3 * u + U_ONE;
         w1 = 3 * u3 - 6 * u2 + 4 * U_ONE;
         w2 = -3 * u3 + 3 * u2 + 3 * u + U_ONE;
         w3 = u3;
         s.x        = blend_axis(w0, w1, w2, w3, a.x, b.x, c.x, d.x);
         s.y        = blend_axis(w0, w1, w2, w3, a.y, b.y, c.y, d.y);
         s.z        = blend_axis(w0, w1, w2, w3, a.z, b.z, c.z, d.z);
         s.end_seg  = end_seg;
         s.last_run = 1'b0;
         sample_q = {sample_q, s};
      end
   endtask

   // expected samples caused by one accepted control point
   task automatic predict_point(input cpoint_type p, input logic last);
      int               first;
      curve_sample_type tail;
      first = sample_q.size();
      // third point opens the list with the start segment and its phantom
      if (points_held == 2)
         push_segment(mirror(hull[1], hull[2]), hull[1], hull[2], p, 1'b0);
      else if (points_held >= 3)
         push_segment(hull[0], hull[1], hull[2], p, 1'b0);
      // final point of a long enough list adds the end segment
      if (last && points_held >= 2)
         push_segment(hull[1], hull[2], p, mirror(p, hull[2]), 1'b1);
      if (sample_q.size() > first) begin
         tail = sample_q[sample_q.size() - 1];
         tail.last_run = 1'b1;
         sample_q[sample_q.size() - 1] = tail;
      end
      hull[0] = hull[1];
      hull[1] = hull[2];
      hull[2] = p;
      // short list or end of list restarts the count
      if (last)
         points_held = 0;
      else if (points_held < 3)
         points_held++;
   endtask

   // input side monitor: feeds the predictor on every accepted item and step write
   always @(posedge clock) begin : watch_inputs
      cpoint_type p;
      if (reset) begin
         for (int i = 0; i < 3; i++) hull[i] = '0;
         points_held = 0;
         model_step  = STEP_MIN;
      end else begin
         if (csr_valid && csr_ready)
            model_step = csr_u_step;
         if (req_valid && req_stall && rsp_stall)
            blocked_cycles++;
         if (req_valid && !req_stall) begin
            p.x = req_point_x;
            p.y = req_point_y;
            p.z = req_point_z;
            predict_point(p, req_last_point);
         end
      end
   end

   // output side checker: each accepted sample against the oldest expectation
   always @(posedge clock) begin : check_samples
      curve_sample_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         samples_checked++;
         if (sample_q.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
               $display("unexpected sample x=%0d y=%0d z=%0d end=%0b last=%0b",
                        rsp_curve_x, rsp_curve_y, rsp_curve_z,
                        rsp_end_segment, rsp_last_of_run);
            mismatches++;
         end else begin
            want = sample_q.pop_front();
            if (rsp_curve_x !== want.x || rsp_curve_y !== want.y ||
                rsp_curve_z !== want.z || rsp_end_segment !== want.end_seg ||
                rsp_last_of_run !== want.last_run) begin
               if (mismatches < REPORT_LIMIT) begin
                  $display("sample %0d: expected x=%0d y=%0d z=%0d end=%0b last=%0b",
                           samples_checked, $signed(want.x), $signed(want.y),
                           $signed(want.z), want.end_seg, want.last_run);
                  $display("   got x=%0d y=%0d z=%0d end=%0b last=%0b",
                           rsp_curve_x, rsp_curve_y, rsp_curve_z,
                           rsp_end_segment, rsp_last_of_run);
               end
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
      return $urandom_range(8, 40);
   endfunction

   // extremes, small values near zero, and full range noise
   function automatic logic signed [COORD_BITS-1:0] rand_coord();
      case ($urandom_range(0, 9))
         0:       return CMAX;
         1:       return CMIN;
         2:       return COORD_BITS'($urandom_range(0, 512)) - COORD_BITS'(256);
         default: return COORD_BITS'($urandom);
      endcase
   endfunction

   // receiver stall process: random gaps, or one long hold-off on request
   initial begin : drive_rsp_stall
      int len;
      forever begin
         @(posedge clock);
         if (rsp_holdoff_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (rsp_holdoff_cycles) @(posedge clock);
            rsp_holdoff_cycles = 0;
            rsp_stall <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            len = pick_gap() + 1;
            rsp_stall <= 1'b1;
            repeat (len) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // offer one control point and hold it until accepted
   task automatic send_point(input logic signed [COORD_BITS-1:0] x,
                             input logic signed [COORD_BITS-1:0] y,
                             input logic signed [COORD_BITS-1:0] z,
                             input logic last);
      int gap;
      req_valid      <= 1'b1;
      req_point_x    <= x;
      req_point_y    <= y;
      req_point_z    <= z;
      req_last_point <= last;
      do @(posedge clock); while (req_stall);
      points_sent++;
      gap = sender_idle ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random_list(input int len);
      for (int i = 0; i < len; i++)
         send_point(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
      lists_sent++;
   endtask

   // drain every expected sample, then let the history update finish
   task automatic wait_block_idle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (sample_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // step register write, only ever called with the block idle
   task automatic set_u_step(input logic [U_FRAC_BITS:0] value);
      csr_valid  <= 1'b1;
      csr_u_step <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // lists of one and two points end without any sample and restart the count
   task automatic test_short_lists();
      send_point(24'sd5, -24'sd5, CMAX, 1'b1);
      send_point(CMIN, 24'sd0, 24'sd1, 1'b0);
      send_point(CMAX, -24'sd1, CMIN, 1'b1);
      lists_sent += 2;
      wait_block_idle();
   endtask

   // shortest full list, a four point list and a long list, all at the reset step
   task automatic test_extreme_lists();
      // alternating extremes push the phantoms far out and saturate both ways
      send_point(CMAX, CMIN, 24'sd0, 1'b0);
      send_point(CMIN, CMAX, -24'sd1, 1'b0);
      send_point(CMAX, CMIN, 24'sd1, 1'b1);
      send_point(24'sd0, 24'sd0, 24'sd0, 1'b0);
      send_point(24'sd1, -24'sd1, 24'sd256, 1'b0);
      send_point(-24'sd256, CMAX, CMIN, 1'b0);
      send_point(CMAX, CMAX, CMAX, 1'b1);
      // long list, list position saturates at three
      send_point(24'sd3, 24'sd7, -24'sd3, 1'b0);
      send_point(CMIN, CMIN, CMIN, 1'b0);
      send_point(24'sd128, -24'sd128, 24'sd0, 1'b0);
      send_point(CMAX, 24'sd0, CMIN, 1'b0);
      send_point(-24'sd2, 24'sd2, 24'sd1000, 1'b0);
      send_point(24'sh555555, 24'shaaaaaa, 24'sh0f0f0f, 1'b1);
      lists_sent += 3;
      wait_block_idle();
   endtask

   // step of exactly one gives two samples per segment, at u = 0 and u = 1
   task automatic test_unit_step();
      set_u_step(STEP_MAX);
      send_point(CMIN, CMIN, CMAX, 1'b0);
      send_point(CMAX, CMAX, CMIN, 1'b0);
      send_point(CMIN, 24'sd0, CMAX, 1'b1);
      lists_sent++;
      wait_block_idle();
      set_u_step(STEP_MIN);
   endtask

   // receiver holds off for a long stretch while points keep coming
   task automatic test_backpressure();
      sender_idle        = 1'b0;
      rsp_idle_on        = 1'b0;
      rsp_holdoff_cycles = HOLDOFF_CYCLES;
      send_random_list(8);
      sender_idle = 1'b1;
      rsp_idle_on = 1'b1;
      wait_block_idle();
   endtask

   // random lists over several step settings, extremes among them
   task automatic test_random_lists();
      int                   budget;
      int                   len;
      bit                   quiet;
      logic [U_FRAC_BITS:0] step;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1:       step = STEP_MAX;
            3:       step = STEP_MIN;
            4:       step = 17'($urandom_range(STEP_MIN, 4096));
            default: step = 17'($urandom_range(STEP_MIN, STEP_MAX));
         endcase
         set_u_step(step);
         budget = 16;
         while (budget > 0) begin
            // some lists run with no idling on either side
            quiet       = ($urandom_range(0, 4) == 0);
            sender_idle = !quiet;
            rsp_idle_on = !quiet;
            // mostly well formed lists, now and then a short one
            if ($urandom_range(0, 6) == 0)
               len = $urandom_range(1, 2);
            else
               len = $urandom_range(3, 8);
            send_random_list(len);
            budget -= len;
         end
         sender_idle = 1'b1;
         rsp_idle_on = 1'b1;
         wait_block_idle();
      end
   endtask

   // watchdog: too long without any accepted item ends the run
   initial begin : watchdog
      int stuck_cycles;
      stuck_cycles = 0;
      while (stuck_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin : run_tests
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_lists();
      test_extreme_lists();
      test_unit_step();
      test_backpressure();
      test_random_lists();

      wait_block_idle();
      if (sample_q.size() != 0) begin
         $display("%0d expected samples never arrived", sample_q.size());
         mismatches += sample_q.size();
      end

      $display("run covered %0d points in %0d lists, %0d curve samples checked",
               points_sent, lists_sent, samples_checked);
      $display("%0d step writes from %0d to %0d, input held off %0d cycles by output stall",
               settings_used, STEP_MIN, STEP_MAX, blocked_cycles);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
